// ----- rtl/csbeq_pkg.sv -----
// ----------------------------------------------------------------------------
// csbeq_pkg
// Types, widths and arithmetic helpers of the two-band shelving equalizer.
// ----------------------------------------------------------------------------
package csbeq_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 18;
    localparam int COEF_FRAC   = COEF_BITS - 3;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W       = PROD_W + 3;   // five products summed
    localparam int CFG_W       = 64;
    localparam int ADDR_W      = 6;
    localparam int FF_W        = 3 * COEF_BITS;
    localparam int FB_W        = 2 * COEF_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    // register map, byte address = 8 * index
    typedef enum logic [2:0] {
        REG_LO_FF = 3'd0,
        REG_LO_FB = 3'd1,
        REG_HI_FF = 3'd2,
        REG_HI_FB = 3'd3,
        REG_GAIN  = 3'd4
    } reg_idx_t;

    // where a registered product goes on the next cycle
    typedef enum logic [2:0] {
        DST_NONE,
        DST_LO_ADD,
        DST_LO_SUB,
        DST_HI_ADD,
        DST_HI_SUB,
        DST_GAIN
    } dst_t;

    // per-channel filter history, one memory word
    typedef struct packed {
        sample_t lx1;
        sample_t lx2;
        sample_t ly1;
        sample_t ly2;
        sample_t hy1;
        sample_t hy2;
    } hist_t;

    typedef struct packed {
        logic    hit;
        sample_t value;
    } sat_t;

    localparam acc_t HALF_COEF = acc_t'(1) <<< (COEF_FRAC - 1);
    localparam acc_t HALF_GAIN = acc_t'(1) <<< (GAIN_FRAC - 1);
    localparam acc_t SAT_MAX   = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
    localparam acc_t SAT_MIN   = -(acc_t'(1) <<< (SAMPLE_BITS - 1));

    // round half up, floor shift, clamp to the sample range
    function automatic sat_t round_sat(input acc_t v, input logic gain_mode);
        acc_t r;
        sat_t s;
        r = gain_mode ? ((v + HALF_GAIN) >>> GAIN_FRAC) : ((v + HALF_COEF) >>> COEF_FRAC);
        if (r > SAT_MAX) begin
            s.hit   = 1'b1;
            s.value = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (r < SAT_MIN) begin
            s.hit   = 1'b1;
            s.value = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            s.hit   = 1'b0;
            s.value = r[SAMPLE_BITS-1:0];
        end
        return s;
    endfunction

endpackage

// ----- rtl/cascaded_shelving_biquad_eq_core.sv -----
// ----------------------------------------------------------------------------
// cascaded_shelving_biquad_eq_core
// Low-shelf then high-shelf biquad (direct form I) with output gain,
// per-channel history in a memory, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_*: s_tdata[23:0] = signed Q1.23 sample, s_tuser[0] =
//    channel. A transaction completes when s_tvalid and s_tready are high.
//  - Result stream m_*: m_tdata[23:0] = equalized sample, m_tuser[0] = clipped
//    (final gain stage saturated). One result per input transaction.
//  - One sample is in flight at a time. s_tready rises together with
//    m_tvalid, so the next input transaction can be taken while the result
//    is offered. The time a sample takes is set by the single 24x18
//    multiplier (eleven products, one per cycle), the history-memory read,
//    finishing and rounding the high-shelf sum before the gain product, and
//    rounding the gain product into the result register.
//  - Coefficients and gain are written over the APB-style port (8-byte
//    stride), by the user only while no sample is in flight (not checked).
//  - Reset restores the register defaults (unity filters and gain) and marks
//    every channel's history as empty, which reads as zero. s_tready stays
//    low while aresetn is low.
//  - If m_tready is low the finished result waits; the sample's history is
//    written back and the next input taken once the result register frees.
// ----------------------------------------------------------------------------
module cascaded_shelving_biquad_eq_core
    import csbeq_pkg::*;
#(
    parameter int CHANNEL_COUNT = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // [23:0] sample_in
    input  logic [0:0]        s_tuser,   // [0] channel
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [23:0] sample_out
    output logic [0:0]        m_tuser,   // [0] clipped
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    localparam int CH_AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // one state per multiplier slot plus read, drain, finalize, done states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LB0,
        ST_LB1,
        ST_LB2,
        ST_LA1,
        ST_LA2,
        ST_HB1,
        ST_HB2,    // low-shelf result rounded here
        ST_HA1,
        ST_HA2,
        ST_HB0,
        ST_HDRAIN,
        ST_HFIN,   // high-shelf result rounded here
        ST_GAIN,
        ST_DONE
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [FF_W-1:0]      lo_ff_reg;
    logic [FB_W-1:0]      lo_fb_reg;
    logic [FF_W-1:0]      hi_ff_reg;
    logic [FB_W-1:0]      hi_fb_reg;
    logic [GAIN_BITS-1:0] gain_reg;
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_ff_reg <= FF_W'(32768);
            lo_fb_reg <= '0;
            hi_ff_reg <= FF_W'(32768);
            hi_fb_reg <= '0;
            gain_reg  <= GAIN_BITS'(4096);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LO_FF: lo_ff_reg <= pwdata[FF_W-1:0];
                REG_LO_FB: lo_fb_reg <= pwdata[FB_W-1:0];
                REG_HI_FF: hi_ff_reg <= pwdata[FF_W-1:0];
                REG_HI_FB: hi_fb_reg <= pwdata[FB_W-1:0];
                REG_GAIN:  gain_reg  <= pwdata[GAIN_BITS-1:0];
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LO_FF: prdata = CFG_W'(lo_ff_reg);
            REG_LO_FB: prdata = CFG_W'(lo_fb_reg);
            REG_HI_FF: prdata = CFG_W'(hi_ff_reg);
            REG_HI_FB: prdata = CFG_W'(hi_fb_reg);
            REG_GAIN:  prdata = CFG_W'(gain_reg);
            default:   prdata = '0;
        endcase
    end

    // coefficient slices
    coef_t lo_b0, lo_b1, lo_b2, lo_a1, lo_a2;
    coef_t hi_b0, hi_b1, hi_b2, hi_a1, hi_a2;
    coef_t gain_coef;

    assign lo_b0 = lo_ff_reg[COEF_BITS-1:0];
    assign lo_b1 = lo_ff_reg[2*COEF_BITS-1:COEF_BITS];
    assign lo_b2 = lo_ff_reg[3*COEF_BITS-1:2*COEF_BITS];
    assign lo_a1 = lo_fb_reg[COEF_BITS-1:0];
    assign lo_a2 = lo_fb_reg[2*COEF_BITS-1:COEF_BITS];
    assign hi_b0 = hi_ff_reg[COEF_BITS-1:0];
    assign hi_b1 = hi_ff_reg[2*COEF_BITS-1:COEF_BITS];
    assign hi_b2 = hi_ff_reg[3*COEF_BITS-1:2*COEF_BITS];
    assign hi_a1 = hi_fb_reg[COEF_BITS-1:0];
    assign hi_a2 = hi_fb_reg[2*COEF_BITS-1:COEF_BITS];
    // unsigned Q4.12 gain as a positive multiplier operand
    assign gain_coef = {{(COEF_BITS-GAIN_BITS){1'b0}}, gain_reg};

    // ------------------------------------------------------------------
    // control and datapath registers
    // ------------------------------------------------------------------
    state_t             state_reg;
    sample_t            x_reg;
    logic [CH_AW-1:0]   ch_reg;
    prod_t              prod_reg;
    dst_t               prod_dst_reg;
    acc_t               acc_lo_reg;
    acc_t               acc_hi_reg;
    sample_t            yl_reg;
    sample_t            yh_reg;
    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;
    logic               m_tuser_reg;

    // history memory
    hist_t              state_mem [CHANNEL_COUNT];
    hist_t              rd_data_reg;
    logic               rd_ok_reg;
    logic [CHANNEL_COUNT-1:0] hist_ok_reg;
    hist_t              hist;
    hist_t              hist_wr;
    logic               wr_en;

    logic               s_fire;
    logic [CH_AW-1:0]   ch_sel;
    sample_t            op_a;
    coef_t              op_b;
    dst_t               op_dst;
    acc_t               prod_ext;
    sat_t               rs_out;
    acc_t               rs_in;
    logic               rs_gain;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid & s_tready;
    assign ch_sel   = (CHANNEL_COUNT > 1) ? CH_AW'(s_tuser[0]) : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // empty history reads as zero
    assign hist = rd_ok_reg ? rd_data_reg : '0;

    assign wr_en = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        hist_wr.lx1 = x_reg;
        hist_wr.lx2 = hist.lx1;
        hist_wr.ly1 = yl_reg;
        hist_wr.ly2 = hist.ly1;
        hist_wr.hy1 = yh_reg;
        hist_wr.hy2 = hist.hy1;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd_data_reg <= state_mem[ch_reg];
        end
        if (wr_en) begin
            state_mem[ch_reg] <= hist_wr;
        end
    end

    // multiplier slot schedule
    always_comb begin
        unique case (state_reg)
            ST_LB0:  begin op_a = x_reg;     op_b = lo_b0;     op_dst = DST_LO_ADD; end
            ST_LB1:  begin op_a = hist.lx1;  op_b = lo_b1;     op_dst = DST_LO_ADD; end
            ST_LB2:  begin op_a = hist.lx2;  op_b = lo_b2;     op_dst = DST_LO_ADD; end
            ST_LA1:  begin op_a = hist.ly1;  op_b = lo_a1;     op_dst = DST_LO_SUB; end
            ST_LA2:  begin op_a = hist.ly2;  op_b = lo_a2;     op_dst = DST_LO_SUB; end
            ST_HB1:  begin op_a = hist.ly1;  op_b = hi_b1;     op_dst = DST_HI_ADD; end
            ST_HB2:  begin op_a = hist.ly2;  op_b = hi_b2;     op_dst = DST_HI_ADD; end
            ST_HA1:  begin op_a = hist.hy1;  op_b = hi_a1;     op_dst = DST_HI_SUB; end
            ST_HA2:  begin op_a = hist.hy2;  op_b = hi_a2;     op_dst = DST_HI_SUB; end
            ST_HB0:  begin op_a = yl_reg;    op_b = hi_b0;     op_dst = DST_HI_ADD; end
            ST_GAIN: begin op_a = yh_reg;    op_b = gain_coef; op_dst = DST_GAIN;   end
            default: begin op_a = '0;        op_b = '0;        op_dst = DST_NONE;   end
        endcase
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // shared round/saturate: low result, high result, then gain stage
    always_comb begin
        unique case (state_reg)
            ST_HB2:  begin rs_in = acc_lo_reg; rs_gain = 1'b0; end
            ST_HFIN: begin rs_in = acc_hi_reg; rs_gain = 1'b0; end
            default: begin rs_in = prod_ext;   rs_gain = 1'b1; end
        endcase
    end

    assign rs_out = round_sat(rs_in, rs_gain);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prod_dst_reg <= DST_NONE;
            m_tvalid_reg <= 1'b0;
            hist_ok_reg  <= '0;
            rd_ok_reg    <= 1'b0;
        end else begin
            // a new result load below takes precedence over the drain
            if (m_tvalid_reg && m_tready && !wr_en) begin
                m_tvalid_reg <= 1'b0;
            end

            // product register and accumulate of the previous product
            prod_dst_reg <= op_dst;
            if (op_dst != DST_NONE) begin
                prod_reg <= op_a * op_b;
            end
            unique case (prod_dst_reg)
                DST_LO_ADD: acc_lo_reg <= acc_lo_reg + prod_ext;
                DST_LO_SUB: acc_lo_reg <= acc_lo_reg - prod_ext;
                DST_HI_ADD: acc_hi_reg <= acc_hi_reg + prod_ext;
                DST_HI_SUB: acc_hi_reg <= acc_hi_reg - prod_ext;
                default: ;
            endcase

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        x_reg     <= $signed(s_tdata[SAMPLE_BITS-1:0]);
                        ch_reg    <= ch_sel;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    rd_ok_reg  <= hist_ok_reg[ch_reg];
                    acc_lo_reg <= '0;
                    acc_hi_reg <= '0;
                    state_reg  <= ST_LB0;
                end
                ST_LB0:    state_reg <= ST_LB1;
                ST_LB1:    state_reg <= ST_LB2;
                ST_LB2:    state_reg <= ST_LA1;
                ST_LA1:    state_reg <= ST_LA2;
                ST_LA2:    state_reg <= ST_HB1;
                ST_HB1:    state_reg <= ST_HB2;
                ST_HB2: begin
                    yl_reg    <= rs_out.value;
                    state_reg <= ST_HA1;
                end
                ST_HA1:    state_reg <= ST_HA2;
                ST_HA2:    state_reg <= ST_HB0;
                ST_HB0:    state_reg <= ST_HDRAIN;
                ST_HDRAIN: state_reg <= ST_HFIN;
                ST_HFIN: begin
                    yh_reg    <= rs_out.value;
                    state_reg <= ST_GAIN;
                end
                ST_GAIN:   state_reg <= ST_DONE;
                ST_DONE: begin
                    // hold until the result register is free
                    if (wr_en) begin
                        m_tdata_reg          <= rs_out.value;
                        m_tuser_reg          <= rs_out.hit;
                        m_tvalid_reg         <= 1'b1;
                        hist_ok_reg[ch_reg]  <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // history write-back and result load happen together
    a_wr_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> m_tvalid)
        else $error("history written without a result");

    // one sample at a time: no new input right after an input transaction
    a_single_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    // low-shelf accumulator is final when its result is rounded
    a_lo_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HB2) |-> (prod_dst_reg != DST_LO_ADD && prod_dst_reg != DST_LO_SUB))
        else $error("low-shelf result rounded before last product");

    // a result load needs a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result overwritten");
`endif

endmodule
